FILE: hw/rtl/nsl_pkg.sv
package nsl_pkg;

    localparam int SPAN_W  = 8;   // source span register width
    localparam int DIM_W   = 11;  // destination span register width
    localparam int POS_W   = 10;  // coordinate field width
    localparam int PIX_W   = 32;  // rgba word
    localparam int IDX_W   = 3;   // config register index width
    localparam int PROD_W  = DIM_W + SPAN_W;  // span times span
    localparam int QUOT_W  = SPAN_W;          // source index never exceeds the source span

    localparam int DEF_MAX_SRC_WIDTH  = 128;
    localparam int DEF_MAX_SRC_HEIGHT = 128;
    localparam int DEF_MAX_DST_DIM    = 1024;

    localparam logic [IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] CFG_BG_RGBA    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_KEEP_ASPECT = 3'd5;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef struct packed {
        logic [SPAN_W-1:0] sw;
        logic [SPAN_W-1:0] sh;
        logic [DIM_W-1:0]  dw;
        logic [DIM_W-1:0]  dh;
        logic [DIM_W-1:0]  inner_w;
        logic [DIM_W-1:0]  inner_h;
        logic [DIM_W-1:0]  left;
        logic [DIM_W-1:0]  top;
        logic [PIX_W-1:0]  bg;
    } t_geom;

endpackage

FILE: hw/rtl/nsl_geom.sv
module nsl_geom #(
    parameter int MAX_SRC_WIDTH  = nsl_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = nsl_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_DST_DIM    = nsl_pkg::DEF_MAX_DST_DIM
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [nsl_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [nsl_pkg::PIX_W-1:0]  i_cfg_data,
    output nsl_pkg::t_geom             o_geom,
    output logic                       o_busy
);
    import nsl_pkg::*;

    localparam logic [2:0] G_IDLE = 3'd0;
    localparam logic [2:0] G_MUL  = 3'd1;
    localparam logic [2:0] G_SEL  = 3'd2;
    localparam logic [2:0] G_DIV  = 3'd3;
    localparam logic [2:0] G_FIN  = 3'd4;

    logic [2:0]        r_state;
    logic [SPAN_W-1:0] r_src_w, r_src_h;
    logic [DIM_W-1:0]  r_dst_w, r_dst_h;
    logic [PIX_W-1:0]  r_bg;
    logic              r_keep;
    logic [PROD_W-1:0] r_ph, r_pw, r_rem;
    logic [SPAN_W-1:0] r_dsr;
    logic              r_tall;
    logic [3:0]        r_cnt;
    logic [DIM_W-1:0]  r_q;
    t_geom             r_geom;

    logic [SPAN_W-1:0] sw, sh;
    logic [DIM_W-1:0]  dw, dh;
    logic [PROD_W-1:0] shifted;
    logic [DIM_W:0]    pad_sum;

    // clamp spans to 1..max
    always_comb begin
        if (r_src_w == '0) sw = SPAN_W'(1);
        else if (32'(r_src_w) > 32'(MAX_SRC_WIDTH)) sw = SPAN_W'(MAX_SRC_WIDTH);
        else sw = r_src_w;
        if (r_src_h == '0) sh = SPAN_W'(1);
        else if (32'(r_src_h) > 32'(MAX_SRC_HEIGHT)) sh = SPAN_W'(MAX_SRC_HEIGHT);
        else sh = r_src_h;
        if (r_dst_w == '0) dw = DIM_W'(1);
        else if (32'(r_dst_w) > 32'(MAX_DST_DIM)) dw = DIM_W'(MAX_DST_DIM);
        else dw = r_dst_w;
        if (r_dst_h == '0) dh = DIM_W'(1);
        else if (32'(r_dst_h) > 32'(MAX_DST_DIM)) dh = DIM_W'(MAX_DST_DIM);
        else dh = r_dst_h;
    end

    assign shifted = PROD_W'(r_dsr) << r_cnt;
    assign pad_sum = r_tall ? ({1'b0, dh} - {1'b0, r_q} + (DIM_W+1)'(1))
                            : ({1'b0, dw} - {1'b0, r_q} + (DIM_W+1)'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_MUL;
            r_src_w <= SPAN_W'(128);
            r_src_h <= SPAN_W'(128);
            r_dst_w <= DIM_W'(128);
            r_dst_h <= DIM_W'(128);
            r_bg    <= '0;
            r_keep  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:   r_src_w <= i_cfg_data[SPAN_W-1:0];
                CFG_SRC_HEIGHT:  r_src_h <= i_cfg_data[SPAN_W-1:0];
                CFG_DST_WIDTH:   r_dst_w <= i_cfg_data[DIM_W-1:0];
                CFG_DST_HEIGHT:  r_dst_h <= i_cfg_data[DIM_W-1:0];
                CFG_BG_RGBA:     r_bg    <= i_cfg_data;
                CFG_KEEP_ASPECT: r_keep  <= i_cfg_data[0];
                default: ;
            endcase
            r_state <= G_MUL;
        end else begin
            case (r_state)
                G_MUL: begin
                    r_ph    <= PROD_W'(dw) * PROD_W'(sh);
                    r_pw    <= PROD_W'(dh) * PROD_W'(sw);
                    r_state <= G_SEL;
                end
                G_SEL: begin
                    r_tall  <= (r_ph <= r_pw);
                    r_rem   <= (r_ph <= r_pw) ? r_ph : r_pw;
                    r_dsr   <= (r_ph <= r_pw) ? sw : sh;
                    r_cnt   <= 4'(DIM_W - 1);
                    r_q     <= '0;
                    r_state <= G_DIV;
                end
                G_DIV: begin
                    if (r_rem >= shifted) begin
                        r_rem        <= r_rem - shifted;
                        r_q[r_cnt]   <= 1'b1;
                    end
                    if (r_cnt == 4'd0) r_state <= G_FIN;
                    else r_cnt <= r_cnt - 4'd1;
                end
                G_FIN: begin
                    r_state <= G_IDLE;
                end
                default: r_state <= G_IDLE;
            endcase
        end
    end

    // geometry latched once the quotient is complete
    always_ff @(posedge i_clk) begin
        if (r_state == G_FIN && !i_cfg_valid) begin
            r_geom.sw <= sw;
            r_geom.sh <= sh;
            r_geom.dw <= dw;
            r_geom.dh <= dh;
            r_geom.bg <= r_bg;
            r_geom.inner_w <= dw;
            r_geom.inner_h <= dh;
            r_geom.left    <= '0;
            r_geom.top     <= '0;
            if (r_keep) begin
                if (r_tall) begin
                    r_geom.inner_h <= r_q;
                    r_geom.top     <= pad_sum[DIM_W:1];
                end else begin
                    r_geom.inner_w <= r_q;
                    r_geom.left    <= pad_sum[DIM_W:1];
                end
            end
        end else if (i_cfg_valid && i_cfg_index == CFG_BG_RGBA) begin
            r_geom.bg <= i_cfg_data;
        end
    end

    assign o_geom = r_geom;
    assign o_busy = (r_state != G_IDLE);

endmodule

FILE: hw/rtl/nsl_divpipe.sv
module nsl_divpipe (
    input  logic                        i_clk,
    input  logic [nsl_pkg::PROD_W-1:0]  i_dividend,
    input  logic [nsl_pkg::DIM_W-1:0]   i_divisor,
    output logic [nsl_pkg::QUOT_W-1:0]  o_quot
);
    import nsl_pkg::*;

    logic [PROD_W-1:0] r_rem [QUOT_W];
    logic [DIM_W-1:0]  r_dvs [QUOT_W];
    logic [QUOT_W-1:0] r_q   [QUOT_W];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        localparam int B = QUOT_W - 1 - k;
        logic [PROD_W-1:0] rem_in, sub;
        logic [DIM_W-1:0]  dvs_in;
        logic [QUOT_W-1:0] q_in;
        logic              ge;
        if (k == 0) begin : g_first
            assign rem_in = i_dividend;
            assign dvs_in = i_divisor;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dvs_in = r_dvs[k-1];
            assign q_in   = r_q[k-1];
        end
        assign sub = PROD_W'(dvs_in) << B;
        assign ge  = (rem_in >= sub);
        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? (rem_in - sub) : rem_in;
            r_dvs[k] <= dvs_in;
            r_q[k]   <= q_in | (QUOT_W'(ge) << B);
        end
    end

    assign o_quot = r_q[QUOT_W-1];

endmodule

FILE: hw/rtl/nsl_store.sv
module nsl_store #(
    parameter int DEPTH  = nsl_pkg::DEF_MAX_SRC_WIDTH * nsl_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int ADDR_W = 14
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_addr,
    input  logic [nsl_pkg::PIX_W-1:0]  i_wdata,
    output logic [nsl_pkg::PIX_W-1:0]  o_rdata
);
    import nsl_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) mem[i_addr] <= i_wdata;
            else r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/nearest_scaler_letterbox.sv
// channel   direction  handshake                      word
// command   in         start & !busy                  i_cmd, i_pos_x, i_pos_y, i_pixel_in
// result    out        o_valid, one cycle, no stall   o_pixel_out, o_in_border
// config    in         i_cfg_valid & o_cfg_ready      i_cfg_index, i_cfg_data
//
// one command per cycle while busy is low; a fetch result reaches the ports through the
// accept register, the 8-stage quotient pipeline, then the address, store read and output
// registers
// loads travel the same pipeline so the store sees writes and reads in command order
// during reset, and after reset or after every config write, busy stays high while the
// letterbox geometry is worked out by a one-bit-per-cycle divider
// reset is synchronous active low; the frame store is not cleared
// results cannot be held off by the receiver, so the pipeline never stalls
module nearest_scaler_letterbox #(
    parameter int MAX_SRC_WIDTH  = nsl_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = nsl_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_DST_DIM    = nsl_pkg::DEF_MAX_DST_DIM
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic [nsl_pkg::POS_W-1:0]  i_pos_x,
    input  logic [nsl_pkg::POS_W-1:0]  i_pos_y,
    input  logic [nsl_pkg::PIX_W-1:0]  i_pixel_in,
    output logic                       o_valid,
    output logic [nsl_pkg::PIX_W-1:0]  o_pixel_out,
    output logic                       o_in_border,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [nsl_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [nsl_pkg::PIX_W-1:0]  i_cfg_data
);
    import nsl_pkg::*;

    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic              fetch;
        logic              border;
        logic              store_ok;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_side;

    t_geom geom;
    logic  geom_busy;
    logic  accept;

    // accept stage
    logic [DIM_W-1:0]  xi, yi;
    logic              out_rng, bx, by;
    t_side             s1_side;
    logic [PROD_W-1:0] xdvd, ydvd;
    logic [DIM_W-1:0]  xdvs, ydvs;

    logic              r_s1_v;
    t_side             r_s1;
    logic [PROD_W-1:0] r_xdvd, r_ydvd;
    logic [DIM_W-1:0]  r_xdvs, r_ydvs;

    // side band beside the quotient pipeline
    logic [QUOT_W-1:0] r_pv;
    t_side             r_sb [QUOT_W];
    logic [QUOT_W-1:0] qx, qy;
    logic [SPAN_W-1:0] sx, sy;

    // address, store and output registers
    logic              r_a_v;
    t_side             r_a;
    logic              r_m_v, r_m_fetch, r_m_border;
    logic [PIX_W-1:0]  rdata;
    logic              r_o_v, r_o_brd;
    logic [PIX_W-1:0]  r_o_pix;
    logic              mem_en;

    nsl_geom #(
        .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
        .MAX_DST_DIM   (MAX_DST_DIM)
    ) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom),
        .o_busy     (geom_busy)
    );

    assign busy        = geom_busy;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !geom_busy;

    // border test and scaled dividends, all from the current geometry
    always_comb begin
        xi      = {1'b0, i_pos_x} - geom.left;
        yi      = {1'b0, i_pos_y} - geom.top;
        out_rng = ({1'b0, i_pos_x} >= geom.dw) || ({1'b0, i_pos_y} >= geom.dh);
        bx      = ({1'b0, i_pos_x} < geom.left) || (xi >= geom.inner_w);
        by      = ({1'b0, i_pos_y} < geom.top) || (yi >= geom.inner_h);

        // a one-pixel span divides zero by one so it lands on index zero
        if (geom.inner_w <= DIM_W'(1)) begin
            xdvd = '0;
            xdvs = DIM_W'(1);
        end else begin
            xdvd = PROD_W'(xi) * PROD_W'(geom.sw);
            xdvs = geom.inner_w - DIM_W'(1);
        end
        if (geom.inner_h <= DIM_W'(1)) begin
            ydvd = '0;
            ydvs = DIM_W'(1);
        end else begin
            ydvd = PROD_W'(yi) * PROD_W'(geom.sh);
            ydvs = geom.inner_h - DIM_W'(1);
        end

        s1_side.fetch    = (i_cmd == CMD_FETCH);
        s1_side.border   = out_rng || bx || by;
        s1_side.store_ok = (i_cmd == CMD_LOAD) &&
                           (32'(i_pos_x) < 32'(MAX_SRC_WIDTH)) &&
                           (32'(i_pos_y) < 32'(MAX_SRC_HEIGHT));
        s1_side.addr     = ADDR_W'(32'(i_pos_y) * 32'(MAX_SRC_WIDTH) + 32'(i_pos_x));
        s1_side.data     = i_pixel_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1   <= s1_side;
        r_xdvd <= xdvd;
        r_xdvs <= xdvs;
        r_ydvd <= ydvd;
        r_ydvs <= ydvs;
    end

    nsl_divpipe u_div_x (
        .i_clk     (i_clk),
        .i_dividend(r_xdvd),
        .i_divisor (r_xdvs),
        .o_quot    (qx)
    );

    nsl_divpipe u_div_y (
        .i_clk     (i_clk),
        .i_dividend(r_ydvd),
        .i_divisor (r_ydvs),
        .o_quot    (qy)
    );

    // valid bits of the side band shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[QUOT_W-2:0], r_s1_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= r_s1;
        for (int k = 1; k < QUOT_W; k++) begin
            r_sb[k] <= r_sb[k-1];
        end
    end

    // quotient can reach the span itself at the far end, pull it back to the last index
    assign sx = (qx > geom.sw - SPAN_W'(1)) ? geom.sw - SPAN_W'(1) : qx;
    assign sy = (qy > geom.sh - SPAN_W'(1)) ? geom.sh - SPAN_W'(1) : qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= r_pv[QUOT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= r_sb[QUOT_W-1];
        if (r_sb[QUOT_W-1].fetch) begin
            r_a.addr <= ADDR_W'(32'(sy) * 32'(MAX_SRC_WIDTH) + 32'(sx));
        end
    end

    // loads write and fetches read at the same stage, so order is kept
    assign mem_en = r_a_v && ((r_a.fetch && !r_a.border) || r_a.store_ok);

    nsl_store #(
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_en   (mem_en),
        .i_we   (r_a.store_ok),
        .i_addr (r_a.addr),
        .i_wdata(r_a.data),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_m_v <= r_a_v;
            r_o_v <= r_m_v && r_m_fetch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_fetch  <= r_a.fetch;
        r_m_border <= r_a.border;
        r_o_brd    <= r_m_border;
        r_o_pix    <= r_m_border ? geom.bg : rdata;
    end

    assign o_valid     = r_o_v;
    assign o_pixel_out = r_o_pix;
    assign o_in_border = r_o_brd;

endmodule
